/* design/lmmw_pkg.sv */
// Shared types, constants and helpers for the lexicographic min/max word finder.
package lmmw_pkg;

  // Longest word kept; later bytes of a word are dropped
  localparam int MAX_LEN = 20;
  // Index into a word store
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  // Word length, 0 .. MAX_LEN
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  // Fixed widths of the word fields
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 5;

  // Three word stores rotate between current, smallest and largest roles
  localparam int NBANK   = 3;
  localparam int SEL_W   = 2;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

  typedef logic [SEL_W-1:0]  bank_sel_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Running comparison codes
  typedef logic [1:0] cmp_t;
  localparam cmp_t CMP_EQ = 2'd0;
  localparam cmp_t CMP_LT = 2'd1;
  localparam cmp_t CMP_GT = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic reporting;
    logic byte_take;
    logic word_end;
    logic emit_load;
    logic session_clear;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_newline;
    logic term_hit;
    logic emit_last;
  } stat_t;

  // Pick a store that holds neither the smallest nor the largest word
  function automatic bank_sel_t free_bank(input bank_sel_t a, input bank_sel_t b);
    bank_sel_t res;
    res = '0;
    for (int i = NBANK - 1; i >= 0; i--) begin
      if (SEL_W'(i) != a && SEL_W'(i) != b) begin
        res = SEL_W'(i);
      end
    end
    return res;
  endfunction

endpackage

/* design/lexicographic_min_max_words_top.sv */
// Top level of the lexicographic smallest/largest word finder.
//
// Input channel (in_valid, in_stall, in_byte): one character word per cycle while in_stall is low.
// A newline ends a word; characters past the twentieth of a word are dropped.
// Every character and newline is taken and gives no result, except a
// newline that ends a word whose kept length equals term_length.
// That word ends the session: in_stall rises and the block reports the
// smallest word, then the largest, one result word per cycle on the output
// channel (out_valid, out_stall, out_which_word, out_byte, out_char_index,
// out_word_len, out_last). The first result is loaded from the report state
// that the ending newline enters; a report gives up to 40 results. out_last
// marks the final result. An empty word gives one result with byte 0. If the
// receiver stalls, the result held in the output register stays and the
// report waits. Input is taken again in the cycle after the final result is
// loaded.
// Configuration: cfg_we writes cfg_term_length (reset value 4); write only
// while idle. Synchronous active-low reset clears the session state.
module lexicographic_min_max_words_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lmmw_pkg::FIELD_W-1:0] cfg_term_length,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lmmw_pkg::BYTE_W-1:0]  in_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_which_word,
  output logic [lmmw_pkg::BYTE_W-1:0]  out_byte,
  output logic [lmmw_pkg::FIELD_W-1:0] out_char_index,
  output logic [lmmw_pkg::FIELD_W-1:0] out_word_len,
  output logic                         out_last
);

  lmmw_pkg::cmd_t  cmd;
  lmmw_pkg::stat_t stat;

  // Sequence input and report
  lmmw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold words and build results
  lmmw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_term_length (cfg_term_length),
    .in_byte         (in_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_which_word  (out_which_word),
    .out_byte        (out_byte),
    .out_char_index  (out_char_index),
    .out_word_len    (out_word_len),
    .out_last        (out_last)
  );

endmodule

/* design/lmmw_ctrl.sv */
// Controller: accept/report sequencing and the result valid flag.
module lmmw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  lmmw_pkg::stat_t stat,
  output lmmw_pkg::cmd_t  cmd
);

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_REPORT = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_take;
  logic out_space;

  assign in_stall  = (state_r != ST_ACCEPT);
  assign in_take   = in_valid && !in_stall;
  assign out_space = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.reporting = (state_r == ST_REPORT);
    unique case (state_r)
      ST_ACCEPT: begin
        if (out_valid_r && !out_stall) begin
          out_valid_nxt = 1'b0;
        end
        cmd.byte_take = in_take && !stat.is_newline;
        cmd.word_end  = in_take && stat.is_newline;
        if (cmd.word_end && stat.term_hit) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_space) begin
          cmd.emit_load = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.emit_last) begin
            cmd.session_clear = 1'b1;
            state_nxt         = ST_ACCEPT;
          end
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

  // Hold state and valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/lmmw_dp.sv */
// Datapath: word stores, running comparisons, role selects and result register.
module lmmw_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lmmw_pkg::FIELD_W-1:0] cfg_term_length,
  input  logic [lmmw_pkg::BYTE_W-1:0]  in_byte,
  input  lmmw_pkg::cmd_t               cmd,
  output lmmw_pkg::stat_t              stat,
  output logic                         out_which_word,
  output logic [lmmw_pkg::BYTE_W-1:0]  out_byte,
  output logic [lmmw_pkg::FIELD_W-1:0] out_char_index,
  output logic [lmmw_pkg::FIELD_W-1:0] out_word_len,
  output logic                         out_last
);

  // Word stores
  lmmw_pkg::byte_t bank_r [lmmw_pkg::NBANK][lmmw_pkg::MAX_LEN];

  lmmw_pkg::bank_sel_t cur_sel_r, cur_sel_nxt;
  lmmw_pkg::bank_sel_t min_sel_r, min_sel_nxt;
  lmmw_pkg::bank_sel_t max_sel_r, max_sel_nxt;
  lmmw_pkg::len_t      cur_len_r, cur_len_nxt;
  lmmw_pkg::len_t      min_len_r, min_len_nxt;
  lmmw_pkg::len_t      max_len_r, max_len_nxt;
  lmmw_pkg::cmp_t      cmp_min_r, cmp_min_nxt;
  lmmw_pkg::cmp_t      cmp_max_r, cmp_max_nxt;
  logic                first_r, first_nxt;
  logic [lmmw_pkg::FIELD_W-1:0] term_len_r;

  logic           emit_which_r, emit_which_nxt;
  lmmw_pkg::idx_t emit_idx_r, emit_idx_nxt;

  logic                         which_r;
  lmmw_pkg::byte_t              byte_r;
  logic [lmmw_pkg::FIELD_W-1:0] cidx_r;
  logic [lmmw_pkg::FIELD_W-1:0] wlen_r;
  logic                         last_r;

  logic            room;
  lmmw_pkg::idx_t  rd_addr;
  lmmw_pkg::byte_t min_byte_r, max_byte_r;
  logic            lt_min, gt_max;
  lmmw_pkg::len_t  emit_len;
  logic            emit_word_end;
  lmmw_pkg::byte_t emit_byte;

  assign room = (cur_len_r < lmmw_pkg::LEN_W'(lmmw_pkg::MAX_LEN));

  // Share one read address, taken from next state: emit index in report,
  // next byte position while collecting
  always_comb begin
    if (cmd.reporting) begin
      rd_addr = emit_idx_nxt;
    end else if (cur_len_nxt < lmmw_pkg::LEN_W'(lmmw_pkg::MAX_LEN)) begin
      rd_addr = cur_len_nxt[lmmw_pkg::IDX_W-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  assign stat.is_newline = (in_byte == lmmw_pkg::NEWLINE);
  assign stat.term_hit   = (lmmw_pkg::FIELD_W'(cur_len_r) == term_len_r)
                           && (cur_len_r <= lmmw_pkg::LEN_W'(lmmw_pkg::MAX_LEN));

  // Final comparison outcome at the end of a word
  assign lt_min = (cmp_min_r == lmmw_pkg::CMP_LT) ||
                  ((cmp_min_r == lmmw_pkg::CMP_EQ) && (cur_len_r < min_len_r));
  assign gt_max = (cmp_max_r == lmmw_pkg::CMP_GT);

  // Report walk
  assign emit_len      = emit_which_r ? max_len_r : min_len_r;
  assign emit_word_end = (emit_len == '0) ||
                         ((lmmw_pkg::LEN_W'(emit_idx_r) + 1'b1) == emit_len);
  assign emit_byte     = (emit_len == '0) ? '0 : (emit_which_r ? max_byte_r : min_byte_r);
  assign stat.emit_last = emit_which_r && emit_word_end;

  // Next word state
  always_comb begin
    cur_sel_nxt    = cur_sel_r;
    min_sel_nxt    = min_sel_r;
    max_sel_nxt    = max_sel_r;
    cur_len_nxt    = cur_len_r;
    min_len_nxt    = min_len_r;
    max_len_nxt    = max_len_r;
    cmp_min_nxt    = cmp_min_r;
    cmp_max_nxt    = cmp_max_r;
    first_nxt      = first_r;
    emit_which_nxt = emit_which_r;
    emit_idx_nxt   = emit_idx_r;

    // Advance running comparisons with an accepted byte
    if (cmd.byte_take && room) begin
      cur_len_nxt = cur_len_r + 1'b1;
      if (cmp_min_r == lmmw_pkg::CMP_EQ) begin
        if (cur_len_r >= min_len_r)     cmp_min_nxt = lmmw_pkg::CMP_GT;
        else if (in_byte < min_byte_r)  cmp_min_nxt = lmmw_pkg::CMP_LT;
        else if (in_byte > min_byte_r)  cmp_min_nxt = lmmw_pkg::CMP_GT;
      end
      if (cmp_max_r == lmmw_pkg::CMP_EQ) begin
        if (cur_len_r >= max_len_r)     cmp_max_nxt = lmmw_pkg::CMP_GT;
        else if (in_byte < max_byte_r)  cmp_max_nxt = lmmw_pkg::CMP_LT;
        else if (in_byte > max_byte_r)  cmp_max_nxt = lmmw_pkg::CMP_GT;
      end
    end

    // Reassign store roles at the end of a word
    if (cmd.word_end) begin
      if (first_r) begin
        min_sel_nxt = cur_sel_r;
        max_sel_nxt = cur_sel_r;
        min_len_nxt = cur_len_r;
        max_len_nxt = cur_len_r;
        first_nxt   = 1'b0;
      end else begin
        if (lt_min) begin
          min_sel_nxt = cur_sel_r;
          min_len_nxt = cur_len_r;
        end
        if (gt_max) begin
          max_sel_nxt = cur_sel_r;
          max_len_nxt = cur_len_r;
        end
      end
      cur_sel_nxt = lmmw_pkg::free_bank(min_sel_nxt, max_sel_nxt);
      cur_len_nxt = '0;
      cmp_min_nxt = lmmw_pkg::CMP_EQ;
      cmp_max_nxt = lmmw_pkg::CMP_EQ;
    end

    // Step through smallest then largest word
    if (cmd.emit_load && emit_word_end) begin
      emit_which_nxt = 1'b1;
      emit_idx_nxt   = '0;
    end else if (cmd.emit_load) begin
      emit_idx_nxt = emit_idx_r + 1'b1;
    end

    // Drop the session after the final result
    if (cmd.session_clear) begin
      cur_len_nxt    = '0;
      min_len_nxt    = '0;
      max_len_nxt    = '0;
      cmp_min_nxt    = lmmw_pkg::CMP_EQ;
      cmp_max_nxt    = lmmw_pkg::CMP_EQ;
      first_nxt      = 1'b1;
      emit_which_nxt = 1'b0;
      emit_idx_nxt   = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_sel_r    <= lmmw_pkg::SEL_W'(0);
      min_sel_r    <= lmmw_pkg::SEL_W'(1);
      max_sel_r    <= lmmw_pkg::SEL_W'(2);
      cur_len_r    <= '0;
      min_len_r    <= '0;
      max_len_r    <= '0;
      cmp_min_r    <= lmmw_pkg::CMP_EQ;
      cmp_max_r    <= lmmw_pkg::CMP_EQ;
      first_r      <= 1'b1;
      emit_which_r <= 1'b0;
      emit_idx_r   <= '0;
      term_len_r   <= lmmw_pkg::FIELD_W'(4);
    end else begin
      cur_sel_r    <= cur_sel_nxt;
      min_sel_r    <= min_sel_nxt;
      max_sel_r    <= max_sel_nxt;
      cur_len_r    <= cur_len_nxt;
      min_len_r    <= min_len_nxt;
      max_len_r    <= max_len_nxt;
      cmp_min_r    <= cmp_min_nxt;
      cmp_max_r    <= cmp_max_nxt;
      first_r      <= first_nxt;
      emit_which_r <= emit_which_nxt;
      emit_idx_r   <= emit_idx_nxt;
      if (cfg_we) begin
        term_len_r <= cfg_term_length;
      end
    end
  end

  // Write the accepted byte into the current store; fetch the smallest and
  // largest bytes needed in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.byte_take && room) begin
      bank_r[cur_sel_r][cur_len_r[lmmw_pkg::IDX_W-1:0]] <= in_byte;
    end
    min_byte_r <= bank_r[min_sel_nxt][rd_addr];
    max_byte_r <= bank_r[max_sel_nxt][rd_addr];
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      which_r <= emit_which_r;
      byte_r  <= emit_byte;
      cidx_r  <= lmmw_pkg::FIELD_W'(emit_idx_r);
      wlen_r  <= lmmw_pkg::FIELD_W'(emit_len);
      last_r  <= stat.emit_last;
    end
  end

  assign out_which_word = which_r;
  assign out_byte       = byte_r;
  assign out_char_index = cidx_r;
  assign out_word_len   = wlen_r;
  assign out_last       = last_r;

endmodule
